[hdl/fwld_pkg.sv]
// Shared types and constants of the fixed-wing landing detector.
package fwld_pkg;

	localparam int DW = 16;
	localparam int SQ_W = 32;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_AIRSPEED_LIMIT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUND_SPEED_LIMIT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIMB_SPEED_LIMIT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIMIT = 8'd3;

	localparam logic [DW-1:0] RST_AIRSPEED_LIMIT = 16'd1536;
	localparam logic [DW-1:0] RST_GROUND_SPEED_LIMIT = 16'd1280;
	localparam logic [DW-1:0] RST_CLIMB_SPEED_LIMIT = 16'd768;
	localparam logic [DW-1:0] RST_ACCEL_LIMIT = 16'd2048;

	localparam logic [DW-1:0] LAUNCH_HOLD_MS = 16'd500;
	localparam logic [DW-1:0] POSITION_TIMEOUT_MS = 16'd1000;
	localparam logic [DW-1:0] AIRSPEED_TIMEOUT_MS = 16'd1000;

	// Q0.16 filter weights: old average, new sample
	localparam logic [DW-1:0] GS_WA = 16'd63570;
	localparam logic [DW-1:0] GS_WB = 16'd1966;
	localparam logic [DW-1:0] CS_WA = 16'd64881;
	localparam logic [DW-1:0] CS_WB = 16'd655;
	localparam logic [DW-1:0] AS_WA = 16'd62259;
	localparam logic [DW-1:0] AS_WB = 16'd3277;
	localparam logic [DW-1:0] AC_WA = 16'd52429;
	localparam logic [DW-1:0] AC_WB = 16'd11796;
	localparam logic [DW-1:0] GS_TIGHTEN = 16'd45875;
	localparam logic [32:0] ROUND_HALF = 33'd32768;

	localparam logic [1:0] FILT_GROUND = 2'd0;
	localparam logic [1:0] FILT_CLIMB = 2'd1;
	localparam logic [1:0] FILT_AIRSPEED = 2'd2;
	localparam logic [1:0] FILT_ACCEL = 2'd3;

	typedef struct packed {
		logic            hold;
		logic            bad;
		logic [SQ_W-1:0] gs_sq;
		logic [SQ_W-1:0] ac_sq;
		logic [DW-1:0]   avd;
		logic [DW-1:0]   tas;
	} cmd_t;

	typedef struct packed {
		logic landed;
		logic bad;
	} res_t;

	typedef struct packed {
		logic [DW-1:0] airspeed;
		logic [DW-1:0] ground;
		logic [DW-1:0] climb;
		logic [DW-1:0] accel;
	} limits_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_FMUL,
		ST_FADD,
		ST_DECIDE,
		ST_PUSH
	} back_state_t;

endpackage

[hdl/fwld_queue.sv]
// Small first-in first-out queue built from registers.
module fwld_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH_LOG2 = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int DEPTH = 1 << DEPTH_LOG2;

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [DEPTH_LOG2:0] wr_ptr_q;
	logic [DEPTH_LOG2:0] rd_ptr_q;
	logic                do_push;
	logic                do_pop;

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full = (wr_ptr_q[DEPTH_LOG2] != rd_ptr_q[DEPTH_LOG2])
		&& (wr_ptr_q[DEPTH_LOG2-1:0] == rd_ptr_q[DEPTH_LOG2-1:0]);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q[DEPTH_LOG2-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q[DEPTH_LOG2-1:0]] <= wdata;
		end
	end

endmodule

[hdl/fwld_front.sv]
// Front end: takes update requests, classifies them and squares the vector parts.
module fwld_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  armed,
	input  logic                  hyst_landed,
	input  logic [15:0]           launch_age_ms,
	input  logic                  launch_in_progress,
	input  logic [15:0]           position_age_ms,
	input  logic signed [15:0]    vel_north,
	input  logic signed [15:0]    vel_east,
	input  logic signed [15:0]    vel_down,
	input  logic [15:0]           true_airspeed,
	input  logic [15:0]           airspeed_age_ms,
	input  logic signed [15:0]    accel_north,
	input  logic signed [15:0]    accel_east,
	output logic                  cmd_push,
	output fwld_pkg::cmd_t        cmd,
	input  logic                  cmd_full
);
	import fwld_pkg::*;

	logic          valid_s1;
	logic          hold_s1;
	logic          bad_s1;
	logic [DW-1:0] avn_s1;
	logic [DW-1:0] ave_s1;
	logic [DW-1:0] avd_s1;
	logic [DW-1:0] aan_s1;
	logic [DW-1:0] aae_s1;
	logic [DW-1:0] tas_s1;

	logic            accept;
	logic            hold;
	logic [SQ_W-1:0] sq_vn;
	logic [SQ_W-1:0] sq_ve;
	logic [SQ_W-1:0] sq_an;
	logic [SQ_W-1:0] sq_ae;

	function automatic logic [DW-1:0] abs16(input logic [DW-1:0] x);
		return x[DW-1] ? (~x + 16'd1) : x;
	endfunction

	assign full = valid_s1 && cmd_full;
	assign accept = push && !full;
	assign cmd_push = valid_s1 && !cmd_full;

	assign hold = !armed
		|| (hyst_landed && (launch_age_ms < LAUNCH_HOLD_MS) && launch_in_progress)
		|| (position_age_ms >= POSITION_TIMEOUT_MS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (cmd_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_s1 <= hold;
			// age 65535 flags a non-finite airspeed and is above the timeout too
			bad_s1 <= (airspeed_age_ms > AIRSPEED_TIMEOUT_MS);
			avn_s1 <= abs16(vel_north);
			ave_s1 <= abs16(vel_east);
			avd_s1 <= abs16(vel_down);
			aan_s1 <= abs16(accel_north);
			aae_s1 <= abs16(accel_east);
			tas_s1 <= true_airspeed;
		end
	end

	assign sq_vn = avn_s1 * avn_s1;
	assign sq_ve = ave_s1 * ave_s1;
	assign sq_an = aan_s1 * aan_s1;
	assign sq_ae = aae_s1 * aae_s1;

	// each sum stays at or below 2^31
	always_comb begin
		cmd.hold = hold_s1;
		cmd.bad = bad_s1;
		cmd.gs_sq = sq_vn + sq_ve;
		cmd.ac_sq = sq_an + sq_ae;
		cmd.avd = avd_s1;
		cmd.tas = tas_s1;
	end

endmodule

[hdl/fwld_isqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
module fwld_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] radicand,
	output logic        done,
	output logic [15:0] root
);
	logic        active_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [31:0] val_q;
	logic [17:0] rem_q;
	logic [15:0] root_q;

	logic [17:0] rem_sh;
	logic [17:0] trial;
	logic        take;

	assign rem_sh = {rem_q[15:0], val_q[31:30]};
	assign trial = {root_q, 2'b01};
	assign take = (rem_sh >= trial);
	assign done = done_q;
	assign root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 4'd15) begin
					active_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (active_q) begin
			val_q <= {val_q[29:0], 2'b00};
			rem_q <= take ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[14:0], take};
		end
	end

endmodule

[hdl/fwld_back.sv]
// Back end: magnitudes, the four low-pass filters and the landed decision.
module fwld_back (
	input  logic              clk,
	input  logic              arst_n,
	input  fwld_pkg::limits_t limits,
	input  logic              cmd_empty,
	input  fwld_pkg::cmd_t    cmd_head,
	output logic              cmd_pop,
	input  logic              res_full,
	output logic              res_push,
	output fwld_pkg::res_t    res_data
);
	import fwld_pkg::*;

	back_state_t state_q;
	back_state_t state_next;

	logic          hold_q;
	logic          bad_q;
	logic          landed_q;
	logic [DW-1:0] avd_q;
	logic [DW-1:0] tas_q;
	logic [DW-1:0] gs_lim_q;
	logic [1:0]    idx_q;
	logic [31:0]   prod_a_q;
	logic [31:0]   prod_b_q;

	logic [DW-1:0] gs_avg_q;
	logic [DW-1:0] cs_avg_q;
	logic [DW-1:0] as_avg_q;
	logic [DW-1:0] ac_avg_q;

	logic          sqrt_start;
	logic          gs_done;
	logic          ac_done;
	logic [DW-1:0] gs_mag;
	logic [DW-1:0] ac_mag;

	logic [DW-1:0] avg_sel;
	logic [DW-1:0] samp_sel;
	logic [DW-1:0] wa_sel;
	logic [DW-1:0] wb_sel;
	logic [32:0]   acc;
	logic [DW-1:0] filt_out;
	logic [31:0]   tight_prod;

	fwld_isqrt u_gs_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (cmd_head.gs_sq),
		.done     (gs_done),
		.root     (gs_mag)
	);

	fwld_isqrt u_ac_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (cmd_head.ac_sq),
		.done     (ac_done),
		.root     (ac_mag)
	);

	always_comb begin
		case (idx_q)
			FILT_GROUND: begin
				avg_sel = gs_avg_q;
				samp_sel = gs_mag;
				wa_sel = GS_WA;
				wb_sel = GS_WB;
			end
			FILT_CLIMB: begin
				avg_sel = cs_avg_q;
				samp_sel = avd_q;
				wa_sel = CS_WA;
				wb_sel = CS_WB;
			end
			FILT_AIRSPEED: begin
				avg_sel = as_avg_q;
				samp_sel = tas_q;
				wa_sel = AS_WA;
				wb_sel = AS_WB;
			end
			default: begin
				avg_sel = ac_avg_q;
				samp_sel = ac_mag;
				wa_sel = AC_WA;
				wb_sel = AC_WB;
			end
		endcase
	end

	assign acc = {1'b0, prod_a_q} + {1'b0, prod_b_q} + ROUND_HALF;
	assign filt_out = (acc[32] != 1'b0) ? 16'hFFFF : acc[31:16];
	assign tight_prod = limits.ground * GS_TIGHTEN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd_pop = 1'b0;
		sqrt_start = 1'b0;
		res_push = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					if (cmd_head.hold) begin
						state_next = ST_PUSH;
					end else begin
						sqrt_start = 1'b1;
						state_next = ST_SQRT;
					end
				end
			end
			ST_SQRT: begin
				if (gs_done) begin
					state_next = ST_FMUL;
				end
			end
			ST_FMUL: begin
				state_next = ST_FADD;
			end
			ST_FADD: begin
				state_next = (idx_q == FILT_ACCEL) ? ST_DECIDE : ST_FMUL;
			end
			ST_DECIDE: begin
				state_next = ST_PUSH;
			end
			ST_PUSH: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_avg_q <= '0;
			cs_avg_q <= '0;
			as_avg_q <= '0;
			ac_avg_q <= '0;
		end else if (state_q == ST_FADD) begin
			case (idx_q)
				FILT_GROUND: gs_avg_q <= filt_out;
				FILT_CLIMB: cs_avg_q <= filt_out;
				FILT_AIRSPEED: as_avg_q <= bad_q ? '0 : filt_out;
				default: ac_avg_q <= filt_out;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			hold_q <= cmd_head.hold;
			bad_q <= cmd_head.bad && !cmd_head.hold;
			landed_q <= 1'b1;
			avd_q <= cmd_head.avd;
			tas_q <= cmd_head.tas;
			gs_lim_q <= cmd_head.bad ? tight_prod[31:16] : limits.ground;
			idx_q <= FILT_GROUND;
		end
		if (state_q == ST_FMUL) begin
			prod_a_q <= avg_sel * wa_sel;
			prod_b_q <= samp_sel * wb_sel;
		end
		if (state_q == ST_FADD) begin
			idx_q <= idx_q + 2'd1;
		end
		if (state_q == ST_DECIDE) begin
			landed_q <= (as_avg_q < limits.airspeed) && (gs_avg_q < gs_lim_q)
				&& (cs_avg_q < limits.climb) && (ac_avg_q < limits.accel);
		end
	end

	always_comb begin
		res_data.landed = landed_q;
		res_data.bad = bad_q;
	end

	a_sqrt_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		gs_done == ac_done)
		else $error("square root units out of step");

	a_sqrt_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		gs_done |-> state_q == ST_SQRT)
		else $error("square root finished outside its wait state");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && hold_q |-> res_data.landed && !res_data.bad)
		else $error("held request did not report landed");

	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> state_q != ST_IDLE)
		else $error("request popped but back end stayed idle");

endmodule

[hdl/fixed_wing_landing_detector.sv]
// Top level of the fixed-wing landing detector.
// One update request in gives one result out: a raw landed flag and an airspeed-bad flag.
// Requests enter through a queue-style push/full port, pass a registered front end that
// checks the disarmed, launch-hold and stale-position cases and squares the velocity and
// acceleration components, then wait in a command queue for the back end. An update that
// runs the filters holds the back end for the two square root units (two bits per cycle,
// 16 steps), a multiply and an add step per filter, then a decide step; a held update
// (disarmed, launch hold or stale position) goes to the result push, leaving the filters
// untouched. Results wait in an output queue read with empty/pop. Limits are written
// through the cfg port (index 0 airspeed, 1 ground speed, 2 climb speed, 3 acceleration;
// others ignored); the user must only do so while the block is idle: it is not checked.
module fixed_wing_landing_detector #(
	parameter int CMD_DEPTH_LOG2 = 1,
	parameter int RES_DEPTH_LOG2 = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic                               armed,
	input  logic                               hyst_landed,
	input  logic [15:0]                        launch_age_ms,
	input  logic                               launch_in_progress,
	input  logic [15:0]                        position_age_ms,
	input  logic signed [15:0]                 vel_north,
	input  logic signed [15:0]                 vel_east,
	input  logic signed [15:0]                 vel_down,
	input  logic [15:0]                        true_airspeed,
	input  logic [15:0]                        airspeed_age_ms,
	input  logic signed [15:0]                 accel_north,
	input  logic signed [15:0]                 accel_east,
	output logic                               empty,
	input  logic                               pop,
	output logic                               landed,
	output logic                               airspeed_bad,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fwld_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [15:0]                        cfg_data
);
	import fwld_pkg::*;

	limits_t limits_q;
	cmd_t    cmd_in;
	cmd_t    cmd_head;
	res_t    res_in;
	res_t    res_out;
	logic    cmd_push;
	logic    cmd_full;
	logic    cmd_pop;
	logic    cmd_empty;
	logic    res_push;
	logic    res_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.airspeed <= RST_AIRSPEED_LIMIT;
			limits_q.ground <= RST_GROUND_SPEED_LIMIT;
			limits_q.climb <= RST_CLIMB_SPEED_LIMIT;
			limits_q.accel <= RST_ACCEL_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_AIRSPEED_LIMIT: limits_q.airspeed <= cfg_data;
				CFG_GROUND_SPEED_LIMIT: limits_q.ground <= cfg_data;
				CFG_CLIMB_SPEED_LIMIT: limits_q.climb <= cfg_data;
				CFG_ACCEL_LIMIT: limits_q.accel <= cfg_data;
				default: ;
			endcase
		end
	end

	fwld_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.armed              (armed),
		.hyst_landed        (hyst_landed),
		.launch_age_ms      (launch_age_ms),
		.launch_in_progress (launch_in_progress),
		.position_age_ms    (position_age_ms),
		.vel_north          (vel_north),
		.vel_east           (vel_east),
		.vel_down           (vel_down),
		.true_airspeed      (true_airspeed),
		.airspeed_age_ms    (airspeed_age_ms),
		.accel_north        (accel_north),
		.accel_east         (accel_east),
		.cmd_push           (cmd_push),
		.cmd                (cmd_in),
		.cmd_full           (cmd_full)
	);

	fwld_queue #(
		.WIDTH      ($bits(cmd_t)),
		.DEPTH_LOG2 (CMD_DEPTH_LOG2)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	fwld_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.limits    (limits_q),
		.cmd_empty (cmd_empty),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_in)
	);

	fwld_queue #(
		.WIDTH      ($bits(res_t)),
		.DEPTH_LOG2 (RES_DEPTH_LOG2)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign landed = res_out.landed;
	assign airspeed_bad = res_out.bad;

endmodule

[bench/fwld_checker.sv]
// Landing detector checker: predicts each result from accepted requests and compares it.
module fwld_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           full,
	input  logic                           armed,
	input  logic                           hyst_landed,
	input  logic [15:0]                    launch_age_ms,
	input  logic                           launch_in_progress,
	input  logic [15:0]                    position_age_ms,
	input  logic signed [15:0]             vel_north,
	input  logic signed [15:0]             vel_east,
	input  logic signed [15:0]             vel_down,
	input  logic [15:0]                    true_airspeed,
	input  logic [15:0]                    airspeed_age_ms,
	input  logic signed [15:0]             accel_north,
	input  logic signed [15:0]             accel_east,
	input  logic                           empty,
	input  logic                           pop,
	input  logic                           landed,
	input  logic                           airspeed_bad,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [fwld_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	output int                             fail_count,
	output int                             outstanding
);
	import fwld_pkg::*;

	limits_t     lim;
	logic [15:0] gs_avg, cs_avg, as_avg, ac_avg;
	res_t        verdict_q[$];
	int          err_cnt = 0;
	int          seen = 0;

	assign fail_count = err_cnt;

	task automatic note_error(input string msg);
		$display("mismatch: %s", msg);
		err_cnt++;
	endtask

	function automatic logic [15:0] root_floor(input logic [31:0] v);
		logic [31:0] rem, res, one;
		rem = v;
		res = '0;
		one = 32'h4000_0000;
		while (one > rem)
			one = one >> 2;
		while (one != 0) begin
			if (rem >= res + one) begin
				rem = rem - (res + one);
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		return res[15:0];
	endfunction

	// -(-32768) wraps to 16'h8000, which read unsigned is the right magnitude
	function automatic logic [15:0] mag16(input logic signed [15:0] x);
		return x[15] ? 16'(-x) : 16'(x);
	endfunction

	function automatic logic [15:0] vec_len(input logic signed [15:0] x,
	                                        input logic signed [15:0] y);
		logic [31:0] a, b;
		a = 32'(mag16(x));
		b = 32'(mag16(y));
		return root_floor(a * a + b * b);
	endfunction

	function automatic logic [15:0] smooth(input logic [15:0] avg, input logic [15:0] sample,
	                                       input logic [15:0] wa, input logic [15:0] wb);
		logic [63:0] acc;
		acc = 64'(avg) * 64'(wa) + 64'(sample) * 64'(wb) + 64'd32768;
		acc = acc >> 16;
		return (acc > 64'd65535) ? 16'hFFFF : acc[15:0];
	endfunction

	task automatic predict_landing(output res_t r);
		logic        hold;
		logic [15:0] gs_cap;
		hold = !armed
			|| (hyst_landed && launch_in_progress && launch_age_ms < LAUNCH_HOLD_MS)
			|| position_age_ms >= POSITION_TIMEOUT_MS;
		r.landed = 1'b1;
		r.bad = 1'b0;
		if (!hold) begin
			gs_avg = smooth(gs_avg, vec_len(vel_north, vel_east), GS_WA, GS_WB);
			cs_avg = smooth(cs_avg, mag16(vel_down), CS_WA, CS_WB);
			r.bad = airspeed_age_ms > AIRSPEED_TIMEOUT_MS;
			as_avg = r.bad ? 16'd0 : smooth(as_avg, true_airspeed, AS_WA, AS_WB);
			ac_avg = smooth(ac_avg, vec_len(accel_north, accel_east), AC_WA, AC_WB);
			gs_cap = r.bad ? 16'((32'(lim.ground) * 32'(GS_TIGHTEN)) >> 16) : lim.ground;
			r.landed = as_avg < lim.airspeed && gs_avg < gs_cap
				&& cs_avg < lim.climb && ac_avg < lim.accel;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			lim.airspeed = RST_AIRSPEED_LIMIT;
			lim.ground = RST_GROUND_SPEED_LIMIT;
			lim.climb = RST_CLIMB_SPEED_LIMIT;
			lim.accel = RST_ACCEL_LIMIT;
			gs_avg = '0;
			cs_avg = '0;
			as_avg = '0;
			ac_avg = '0;
			verdict_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_AIRSPEED_LIMIT: lim.airspeed = cfg_data;
					CFG_GROUND_SPEED_LIMIT: lim.ground = cfg_data;
					CFG_CLIMB_SPEED_LIMIT: lim.climb = cfg_data;
					CFG_ACCEL_LIMIT: lim.accel = cfg_data;
					default: ;
				endcase
			end
			if (push && !full) begin
				predict_landing(want);
				verdict_q.push_back(want);
			end
			if (pop && !empty) begin
				if (verdict_q.size() == 0) begin
					note_error($sformatf("result %0d arrived with nothing pending", seen));
				end else begin
					want = verdict_q.pop_front();
					if (landed !== want.landed || airspeed_bad !== want.bad)
						note_error($sformatf("result %0d landed %b want %b, airspeed_bad %b want %b",
							seen, landed, want.landed, airspeed_bad, want.bad));
				end
				seen++;
			end
			outstanding <= verdict_q.size();
		end
	end

endmodule

[bench/testbench.sv]
// Top of the landing detector bench: clock, reset, request and result traffic, verdict.
module testbench;
	import fwld_pkg::*;

	localparam int LONG_HOLD = 400;
	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_ITEMS = 160;
	localparam int DRAIN_TAIL = 64;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd9;

	typedef enum int {
		RG_CALM,
		RG_FLIGHT,
		RG_WILD
	} regime_t;

	typedef struct {
		logic        armed;
		logic        hyst;
		logic [15:0] launch_age;
		logic        launching;
		logic [15:0] pos_age;
		logic [15:0] vn, ve, vd;
		logic [15:0] tas;
		logic [15:0] as_age;
		logic [15:0] an, ae;
	} update_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic                 armed = 1'b0;
	logic                 hyst_landed = 1'b0;
	logic [15:0]          launch_age_ms = '0;
	logic                 launch_in_progress = 1'b0;
	logic [15:0]          position_age_ms = '0;
	logic signed [15:0]   vel_north = '0;
	logic signed [15:0]   vel_east = '0;
	logic signed [15:0]   vel_down = '0;
	logic [15:0]          true_airspeed = '0;
	logic [15:0]          airspeed_age_ms = '0;
	logic signed [15:0]   accel_north = '0;
	logic signed [15:0]   accel_east = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic                 landed;
	logic                 airspeed_bad;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;
	int                   fail_count;
	int                   outstanding;
	int                   squeeze_req = 0;

	fixed_wing_landing_detector i_dut (.*);

	fwld_checker i_check (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [15:0] spread(input int r);
		return 16'(int'($urandom_range(0, 2 * r)) - r);
	endfunction

	function automatic update_t at_rest();
		update_t u;
		u.armed = 1'b1;
		u.hyst = 1'b0;
		u.launch_age = 16'hFFFF;
		u.launching = 1'b0;
		u.pos_age = '0;
		u.vn = '0;
		u.ve = '0;
		u.vd = '0;
		u.tas = '0;
		u.as_age = '0;
		u.an = '0;
		u.ae = '0;
		return u;
	endfunction

	function automatic update_t make_update(input regime_t regime);
		update_t u;
		int roll;
		u = at_rest();
		u.hyst = 1'($urandom_range(0, 1));
		u.launching = ($urandom_range(0, 3) == 0);
		u.launch_age = 16'($urandom_range(0, 65535));
		u.pos_age = 16'($urandom_range(0, 999));
		roll = $urandom_range(0, 99);
		if (roll < 6) begin
			u.armed = 1'b0;
		end else if (roll < 11) begin
			u.hyst = 1'b1;
			u.launching = 1'b1;
			u.launch_age = 16'($urandom_range(0, 499));
		end else if (roll < 15) begin
			u.pos_age = 16'($urandom_range(1000, 65535));
		end
		roll = $urandom_range(0, 99);
		if (roll < 85)
			u.as_age = 16'($urandom_range(0, 1000));
		else if (roll < 95)
			u.as_age = 16'($urandom_range(1001, 65534));
		else
			u.as_age = 16'hFFFF;
		case (regime)
			RG_CALM: begin
				u.vn = spread(300);
				u.ve = spread(300);
				u.vd = spread(200);
				u.tas = 16'($urandom_range(0, 1400));
				u.an = spread(1200);
				u.ae = spread(1200);
			end
			RG_FLIGHT: begin
				u.vn = spread(9000);
				u.ve = spread(9000);
				u.vd = spread(3000);
				u.tas = 16'($urandom_range(1000, 9000));
				u.an = spread(6000);
				u.ae = spread(6000);
			end
			default: begin
				u.armed = 1'($urandom_range(0, 1));
				u.hyst = 1'($urandom_range(0, 1));
				u.launching = 1'($urandom_range(0, 1));
				u.launch_age = 16'($urandom);
				u.pos_age = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 999));
				u.vn = 16'($urandom);
				u.ve = 16'($urandom);
				u.vd = 16'($urandom);
				u.tas = 16'($urandom);
				u.as_age = 16'($urandom);
				u.an = 16'($urandom);
				u.ae = 16'($urandom);
			end
		endcase
		return u;
	endfunction

	task automatic offer(input update_t u);
		push <= 1'b1;
		armed <= u.armed;
		hyst_landed <= u.hyst;
		launch_age_ms <= u.launch_age;
		launch_in_progress <= u.launching;
		position_age_ms <= u.pos_age;
		vel_north <= u.vn;
		vel_east <= u.ve;
		vel_down <= u.vd;
		true_airspeed <= u.tas;
		airspeed_age_ms <= u.as_age;
		accel_north <= u.an;
		accel_east <= u.ae;
		do @(posedge clk); while (full);
	endtask

	task automatic rest(input int cycles);
		push <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// the extra edge lets the checker count a request taken at this edge
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_limits(input logic [15:0] as_lim, input logic [15:0] gs_lim,
	                           input logic [15:0] cs_lim, input logic [15:0] ac_lim,
	                           input bit poke_unused);
		wait_drained();
		write_reg(CFG_AIRSPEED_LIMIT, as_lim);
		write_reg(CFG_GROUND_SPEED_LIMIT, gs_lim);
		write_reg(CFG_CLIMB_SPEED_LIMIT, cs_lim);
		write_reg(CFG_ACCEL_LIMIT, ac_lim);
		if (poke_unused)
			write_reg(CFG_UNUSED, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int count);
		int done, seg, burst, gap, k, pause_at, roll;
		regime_t regime;
		done = 0;
		pause_at = $urandom_range(count / 4, 3 * count / 4);
		while (done < count) begin
			roll = $urandom_range(0, 99);
			regime = (roll < 45) ? RG_CALM : (roll < 80) ? RG_FLIGHT : RG_WILD;
			seg = $urandom_range(20, 90);
			while (seg > 0 && done < count) begin
				burst = $urandom_range(1, 16);
				for (k = 0; k < burst && seg > 0 && done < count; k++) begin
					offer(make_update(regime));
					seg--;
					done++;
					if (done == pause_at)
						wait_drained();
				end
				gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
				if (gap > 0)
					rest(gap);
			end
		end
	endtask

	initial begin : result_sink
		int served, mode, span;
		served = 0;
		forever begin
			if (squeeze_req != served) begin
				served = squeeze_req;
				pop <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 2);
				span = $urandom_range(10, 150);
				repeat (span) begin
					case (mode)
						0: pop <= 1'b1;
						1: pop <= 1'($urandom_range(0, 1));
						default: pop <= ($urandom_range(0, 7) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		update_t u;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests under reset limits
		offer(at_rest());
		u = at_rest();
		u.armed = 1'b0;
		u.hyst = 1'b1;
		u.launch_age = '0;
		u.launching = 1'b1;
		u.pos_age = 16'hFFFF;
		u.vn = 16'h8000;
		u.ve = 16'h7FFF;
		u.vd = 16'h8000;
		u.tas = 16'hFFFF;
		u.as_age = 16'hFFFF;
		u.an = 16'h8000;
		u.ae = 16'h7FFF;
		offer(u);
		// launch hold, then each of its three terms alone missing
		u = at_rest();
		u.hyst = 1'b1;
		u.launching = 1'b1;
		u.launch_age = 16'd499;
		u.vn = 16'h7FFF;
		offer(u);
		u.vn = 16'd2000;
		u.launch_age = 16'd500;
		offer(u);
		u.launch_age = '0;
		u.hyst = 1'b0;
		offer(u);
		u.hyst = 1'b1;
		u.launching = 1'b0;
		offer(u);
		// position age around the timeout
		u = at_rest();
		u.pos_age = 16'd999;
		u.vd = 16'd500;
		offer(u);
		u.pos_age = 16'd1000;
		offer(u);
		u.pos_age = 16'hFFFF;
		offer(u);
		// airspeed age around the timeout and the non-finite mark
		u = at_rest();
		u.tas = 16'hFFFF;
		u.as_age = 16'd1000;
		offer(u);
		u.as_age = 16'd1001;
		offer(u);
		u.as_age = 16'hFFFF;
		offer(u);
		u.as_age = '0;
		offer(u);
		// component extremes
		u = at_rest();
		u.vn = 16'h8000;
		u.ve = 16'h8000;
		u.vd = 16'h8000;
		u.an = 16'h8000;
		u.ae = 16'h8000;
		offer(u);
		u.vn = 16'h7FFF;
		u.ve = 16'h7FFF;
		u.vd = 16'h7FFF;
		u.an = 16'h7FFF;
		u.ae = 16'h7FFF;
		u.tas = 16'hFFFF;
		offer(u);
		offer(at_rest());
		offer(at_rest());

		run_random(PHASE_ITEMS);

		load_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		squeeze_req++;
		run_random(PHASE_ITEMS);

		load_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		run_random(PHASE_ITEMS);

		// ground limit 1 tightens to zero
		load_limits(16'd3000, 16'd1, 16'd500, 16'd4000, 1'b0);
		run_random(PHASE_ITEMS);

		load_limits(16'($urandom_range(256, 6000)), 16'($urandom_range(256, 6000)),
			16'($urandom_range(256, 6000)), 16'($urandom_range(256, 6000)), 1'b0);
		run_random(PHASE_ITEMS);

		load_limits(RST_AIRSPEED_LIMIT, RST_GROUND_SPEED_LIMIT, RST_CLIMB_SPEED_LIMIT,
			RST_ACCEL_LIMIT, 1'b1);
		run_random(PHASE_ITEMS);

		wait_drained();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[fixed_wing_landing_detector.f]
hdl/fwld_pkg.sv
hdl/fwld_queue.sv
hdl/fwld_front.sv
hdl/fwld_isqrt.sv
hdl/fwld_back.sv
hdl/fixed_wing_landing_detector.sv
bench/fwld_checker.sv
bench/testbench.sv
